// ----- hdl/rtbmp_pkg.sv -----
// Shared types, constants and tables of the recurrence term engine.
// Depends on nothing; every other file of the block uses it.
package rtbmp_pkg;

    localparam int unsigned RES_W = 30;

    typedef logic [RES_W-1:0] residue_t;
    typedef logic [1:0]       bank_t;
    typedef logic [3:0]       entry_t;
    typedef logic [5:0]       mat_addr_t;

    localparam logic [31:0] MODULUS     = 32'd1000000007;
    localparam logic [31:0] TWO_MODULUS = 32'd2000000014;
    localparam logic [30:0] BARRETT_MU  = 31'((64'd1 << 60) / 64'd1000000007);

    localparam int unsigned RAM_DEPTH = 48;

    localparam bank_t BANK_BASE_INIT = 2'd0;
    localparam bank_t BANK_ACC_INIT  = 2'd1;
    localparam bank_t BANK_SCR_INIT  = 2'd2;

    localparam residue_t NEG_ONE = residue_t'(MODULUS - 32'd1);

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // Companion matrix, row-major, with negative entries held as the modulus minus one.
    function automatic residue_t companion_entry(entry_t idx);
        residue_t val;
        unique case (idx)
            4'd3:    val = NEG_ONE;
            4'd4:    val = residue_t'(1);
            4'd7:    val = residue_t'(1);
            4'd9:    val = residue_t'(1);
            4'd11:   val = NEG_ONE;
            4'd14:   val = residue_t'(1);
            4'd15:   val = residue_t'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic residue_t identity_entry(entry_t idx);
        residue_t val;
        val = (idx[1:0] == idx[3:2]) ? residue_t'(1) : '0;
        return val;
    endfunction

    function automatic residue_t start_term(logic [1:0] idx);
        residue_t val;
        unique case (idx)
            2'd0: val = residue_t'(1);
            2'd1: val = residue_t'(3);
            2'd2: val = residue_t'(6);
            2'd3: val = residue_t'(10);
        endcase
        return val;
    endfunction

endpackage

// ----- hdl/rtbmp_if.sv -----
// Valid/ready channel interfaces for the request and response beats.
// Depends on rtbmp_pkg for the residue width.
interface rtbmp_req_if #(
    parameter int unsigned INDEX_WIDTH = 63
) ();
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] term_index;

    modport source (output valid, output term_index, input ready);
    modport sink   (input valid, input term_index, output ready);
endinterface

interface rtbmp_rsp_if ();
    logic                         valid;
    logic                         ready;
    logic [rtbmp_pkg::RES_W-1:0]  term_value;

    modport source (output valid, output term_value, input ready);
    modport sink   (input valid, input term_value, output ready);
endinterface

// ----- hdl/rtbmp_mat_ram.sv -----
// Matrix store: three banks of sixteen residues, one write port and two registered reads.
// Depends on rtbmp_pkg for the address and data types.
module rtbmp_mat_ram (
    input  logic                 clk,
    input  logic                 we,
    input  rtbmp_pkg::mat_addr_t waddr,
    input  rtbmp_pkg::residue_t  wdata,
    input  rtbmp_pkg::mat_addr_t raddr_a,
    input  rtbmp_pkg::mat_addr_t raddr_b,
    output rtbmp_pkg::residue_t  rdata_a,
    output rtbmp_pkg::residue_t  rdata_b
);
    import rtbmp_pkg::*;

    residue_t mem [0:RAM_DEPTH-1];
    residue_t rdata_a_reg;
    residue_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- hdl/rtbmp_modmac.sv -----
// Pipelined modular multiply-accumulate: product, Barrett reduction, modular running sum.
// Depends on rtbmp_pkg for the modulus, the reduction constant and the control struct.
module rtbmp_modmac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtbmp_pkg::mac_ctl_t  in_ctl,
    input  rtbmp_pkg::residue_t  a,
    input  rtbmp_pkg::residue_t  b,
    output logic                 res_valid,
    output rtbmp_pkg::residue_t  res
);
    import rtbmp_pkg::*;

    mac_ctl_t    ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [59:0] prod1_reg;
    logic [31:0] x2_reg, x3_reg;
    logic [30:0] q2_reg;
    logic [31:0] qp3_reg;
    residue_t    r4_reg;
    residue_t    acc_reg;
    logic        res_valid_reg;

    logic [59:0] prod;
    logic [61:0] quot_prod;
    logic [60:0] qp_prod;
    logic [31:0] diff;
    residue_t    r_red;
    logic [30:0] sum;
    residue_t    acc_next;

    assign prod      = 60'(a) * 60'(b);
    assign quot_prod = 62'(prod1_reg[59:29]) * 62'(BARRETT_MU);
    assign qp_prod   = 61'(q2_reg) * 61'(MODULUS);
    assign diff      = x3_reg - qp3_reg;

    // The Barrett estimate leaves the remainder below three times the modulus.
    always_comb
    begin
        priority if (diff >= TWO_MODULUS)
        begin
            r_red = residue_t'(diff - TWO_MODULUS);
        end
        else if (diff >= MODULUS)
        begin
            r_red = residue_t'(diff - MODULUS);
        end
        else
        begin
            r_red = residue_t'(diff);
        end
    end

    always_comb
    begin
        sum = ctl4_reg.first ? 31'(r4_reg) : (31'(acc_reg) + 31'(r4_reg));
        if (32'(sum) >= MODULUS)
        begin
            acc_next = residue_t'(32'(sum) - MODULUS);
        end
        else
        begin
            acc_next = residue_t'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            ctl3_reg      <= '0;
            ctl4_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg      <= in_ctl;
            ctl2_reg      <= ctl1_reg;
            ctl3_reg      <= ctl2_reg;
            ctl4_reg      <= ctl3_reg;
            res_valid_reg <= ctl4_reg.valid && ctl4_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod;
        x2_reg    <= prod1_reg[31:0];
        q2_reg    <= quot_prod[61:31];
        x3_reg    <= x2_reg;
        qp3_reg   <= qp_prod[31:0];
        r4_reg    <= r_red;
        if (ctl4_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = acc_reg;

endmodule

// ----- hdl/recurrence_term_by_matrix_power.sv -----
// Top level of the recurrence term engine: sequencer, matrix store and shared modular MAC.
// Depends on rtbmp_pkg, rtbmp_if, rtbmp_mat_ram and rtbmp_modmac.
//
// The block takes an index n on the request channel and returns term n, modulo 1000000007,
// of a(i) = 2a(i-1) - a(i-2) + a(i-3) - a(i-4) with a(1..4) = 1, 3, 6, 10, on the response
// channel. Index zero answers 0 and indexes one to four answer the start term. Larger
// indexes load the companion and identity matrices, then raise the companion matrix to the
// power n-4 by repeated squaring; each 4x4 product issues 64 multiply-reduce operations, one
// per cycle, into a single pipelined modular multiplier and waits for the pipeline to drain.
// Every exponent bit passes through a multiply decision and a squaring decision, and a
// closing dot product with the start terms gives the result. The request side is ready only
// while the sequencer is idle; the result sits in an output register, so a new index is taken
// while an earlier result still waits, and the sequencer stalls before its own result until
// that register is free.
module recurrence_term_by_matrix_power #(
    parameter int unsigned INDEX_WIDTH = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    rtbmp_req_if.sink   request,
    rtbmp_rsp_if.source response
);
    import rtbmp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_STEP = 6'b000100,
        S_MUL  = 6'b001000,
        S_DOT  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [INDEX_WIDTH-1:0] exponent_left_reg, exponent_left_next;
    logic                   sq_phase_reg, sq_phase_next;
    logic                   mul_acc_reg, mul_acc_next;
    bank_t                  base_bank_reg, base_bank_next;
    bank_t                  acc_bank_reg, acc_bank_next;
    bank_t                  scr_bank_reg, scr_bank_next;
    logic [5:0]             issue_cnt_reg, issue_cnt_next;
    logic                   issuing_reg, issuing_next;
    entry_t                 res_cnt_reg, res_cnt_next;
    logic [4:0]             init_cnt_reg, init_cnt_next;
    residue_t               result_reg, result_next;
    mac_ctl_t               iss_ctl_reg, iss_ctl_next;
    logic                   iss_dot_reg, iss_dot_next;
    logic [1:0]             iss_term_reg, iss_term_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    residue_t               rsp_value_reg, rsp_value_next;

    logic                   we;
    mat_addr_t              waddr;
    residue_t               wdata;
    mat_addr_t              raddr_a;
    mat_addr_t              raddr_b;
    residue_t               rdata_a;
    residue_t               rdata_b;
    residue_t               mac_b;
    logic                   mac_res_valid;
    residue_t               mac_res;

    logic [INDEX_WIDTH-1:0] n_in;
    logic                   accept;
    logic [1:0]             iss_r, iss_c, iss_k;
    bank_t                  x_bank;

    assign n_in   = request.term_index;
    assign accept = request.valid && request.ready;

    assign request.ready       = (state_reg == S_IDLE);
    assign response.valid      = rsp_valid_reg;
    assign response.term_value = rsp_value_reg;

    assign {iss_r, iss_c, iss_k} = issue_cnt_reg;
    assign x_bank = mul_acc_reg ? acc_bank_reg : base_bank_reg;

    assign raddr_a = (state_reg == S_DOT) ? {acc_bank_reg, issue_cnt_reg[1:0], 2'b11}
                                          : {x_bank, iss_r, iss_k};
    assign raddr_b = {base_bank_reg, iss_k, iss_c};
    assign mac_b   = iss_dot_reg ? start_term(iss_term_reg) : rdata_b;

    always_comb
    begin
        we    = 1'b0;
        waddr = {scr_bank_reg, res_cnt_reg};
        wdata = mac_res;
        if (state_reg == S_INIT)
        begin
            we = 1'b1;
            if (init_cnt_reg[4])
            begin
                waddr = {acc_bank_reg, init_cnt_reg[3:0]};
                wdata = identity_entry(init_cnt_reg[3:0]);
            end
            else
            begin
                waddr = {base_bank_reg, init_cnt_reg[3:0]};
                wdata = companion_entry(init_cnt_reg[3:0]);
            end
        end
        else if (state_reg == S_MUL)
        begin
            we = mac_res_valid;
        end
    end

    rtbmp_mat_ram u_mat_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    rtbmp_modmac u_modmac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (iss_ctl_reg),
        .a         (rdata_a),
        .b         (mac_b),
        .res_valid (mac_res_valid),
        .res       (mac_res)
    );

    always_comb
    begin
        state_next         = state_reg;
        exponent_left_next = exponent_left_reg;
        sq_phase_next      = sq_phase_reg;
        mul_acc_next       = mul_acc_reg;
        base_bank_next     = base_bank_reg;
        acc_bank_next      = acc_bank_reg;
        scr_bank_next      = scr_bank_reg;
        issue_cnt_next     = issue_cnt_reg;
        issuing_next       = issuing_reg;
        res_cnt_next       = res_cnt_reg;
        init_cnt_next      = init_cnt_reg;
        result_next        = result_reg;
        iss_ctl_next       = '0;
        iss_dot_next       = 1'b0;
        iss_term_next      = iss_term_reg;
        rsp_valid_next     = rsp_valid_reg && !response.ready;
        rsp_value_next     = rsp_value_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (n_in == '0)
                    begin
                        result_next = '0;
                        state_next  = S_DONE;
                    end
                    else if (n_in <= INDEX_WIDTH'(4))
                    begin
                        result_next = start_term(2'(n_in[1:0] - 2'd1));
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        exponent_left_next = n_in - INDEX_WIDTH'(4);
                        init_cnt_next      = '0;
                        sq_phase_next      = 1'b0;
                        base_bank_next     = BANK_BASE_INIT;
                        acc_bank_next      = BANK_ACC_INIT;
                        scr_bank_next      = BANK_SCR_INIT;
                        state_next         = S_INIT;
                    end
                end
            end

            S_INIT:
            begin
                init_cnt_next = init_cnt_reg + 5'd1;
                if (init_cnt_reg == 5'd31)
                begin
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                priority if (exponent_left_reg == '0)
                begin
                    issuing_next   = 1'b1;
                    issue_cnt_next = '0;
                    state_next     = S_DOT;
                end
                else if (!sq_phase_reg)
                begin
                    sq_phase_next = 1'b1;
                    if (exponent_left_reg[0])
                    begin
                        mul_acc_next   = 1'b1;
                        issuing_next   = 1'b1;
                        issue_cnt_next = '0;
                        res_cnt_next   = '0;
                        state_next     = S_MUL;
                    end
                end
                else
                begin
                    sq_phase_next      = 1'b0;
                    exponent_left_next = exponent_left_reg >> 1;
                    if ((exponent_left_reg >> 1) != '0)
                    begin
                        mul_acc_next   = 1'b0;
                        issuing_next   = 1'b1;
                        issue_cnt_next = '0;
                        res_cnt_next   = '0;
                        state_next     = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                if (issuing_reg)
                begin
                    iss_ctl_next.valid = 1'b1;
                    iss_ctl_next.first = (iss_k == 2'd0);
                    iss_ctl_next.last  = (iss_k == 2'd3);
                    issue_cnt_next     = issue_cnt_reg + 6'd1;
                    if (issue_cnt_reg == 6'd63)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (mac_res_valid)
                begin
                    res_cnt_next = res_cnt_reg + 4'd1;
                    if (res_cnt_reg == 4'd15)
                    begin
                        // The finished product becomes the destination; the old one is scratch.
                        if (mul_acc_reg)
                        begin
                            acc_bank_next = scr_bank_reg;
                            scr_bank_next = acc_bank_reg;
                        end
                        else
                        begin
                            base_bank_next = scr_bank_reg;
                            scr_bank_next  = base_bank_reg;
                        end
                        state_next = S_STEP;
                    end
                end
            end

            S_DOT:
            begin
                if (issuing_reg)
                begin
                    iss_ctl_next.valid = 1'b1;
                    iss_ctl_next.first = (issue_cnt_reg[1:0] == 2'd0);
                    iss_ctl_next.last  = (issue_cnt_reg[1:0] == 2'd3);
                    iss_dot_next       = 1'b1;
                    iss_term_next      = issue_cnt_reg[1:0];
                    issue_cnt_next     = issue_cnt_reg + 6'd1;
                    if (issue_cnt_reg[1:0] == 2'd3)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (mac_res_valid)
                begin
                    result_next = mac_res;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || response.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_value_next = result_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            exponent_left_reg <= '0;
            sq_phase_reg      <= 1'b0;
            mul_acc_reg       <= 1'b0;
            base_bank_reg     <= BANK_BASE_INIT;
            acc_bank_reg      <= BANK_ACC_INIT;
            scr_bank_reg      <= BANK_SCR_INIT;
            issue_cnt_reg     <= '0;
            issuing_reg       <= 1'b0;
            res_cnt_reg       <= '0;
            init_cnt_reg      <= '0;
            iss_ctl_reg       <= '0;
            iss_dot_reg       <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            exponent_left_reg <= exponent_left_next;
            sq_phase_reg      <= sq_phase_next;
            mul_acc_reg       <= mul_acc_next;
            base_bank_reg     <= base_bank_next;
            acc_bank_reg      <= acc_bank_next;
            scr_bank_reg      <= scr_bank_next;
            issue_cnt_reg     <= issue_cnt_next;
            issuing_reg       <= issuing_next;
            res_cnt_reg       <= res_cnt_next;
            init_cnt_reg      <= init_cnt_next;
            iss_ctl_reg       <= iss_ctl_next;
            iss_dot_reg       <= iss_dot_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        iss_term_reg  <= iss_term_next;
        rsp_value_reg <= rsp_value_next;
    end

endmodule
